// ===== rtl/core/eatbv_pkg.sv =====
`timescale 1ns / 1ps

package eatbv_pkg;

	// Field widths
	localparam int ANGLE_W = 16;
	localparam int OUT_W   = 16;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 16;
	localparam int XY_W         = 32;
	localparam int Z_W          = 25;
	localparam int TRIG_W       = 22;

	// Gain-compensated 1.0 at scale 2^28
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd163008218;

	// atan(2^-i) in degrees * 2^16, rounded
	localparam logic signed [Z_W-1:0] ATAN_DEG16 [CORDIC_STEPS] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
		25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
		25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
		25'sd917,     25'sd458,     25'sd229,    25'sd115
	};

	// State carried from cell to cell
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   neg_cos;
	} cordic_t;

	// Sine and cosine at scale 2^20
	typedef struct packed {
		logic signed [TRIG_W-1:0] sn;
		logic signed [TRIG_W-1:0] cs;
	} trig_t;

endpackage

// ===== rtl/core/euler_angles_to_basis_vectors.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ----------------------------------------
// in        input      in_valid / in_stall  pitch, yaw, roll (deg*128, signed 16)
// out       output     out_valid/out_stall  forward_*, right_*, up_* (Q1.14, signed 16)
//
// One transfer per cycle is taken and given unless the output stalls. Stages:
// one fold, sixteen CORDIC cells per angle, one rounding, five product stages.
// Reset clears only the valid bits of the pipeline.
// A stall on the output while a result is held freezes every stage; in_stall
// follows it in the same cycle. A stall with no result held is ignored.

module euler_angles_to_basis_vectors import eatbv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [ANGLE_W-1:0] pitch,
	input  logic signed [ANGLE_W-1:0] yaw,
	input  logic signed [ANGLE_W-1:0] roll,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] forward_x,
	output logic signed [OUT_W-1:0] forward_y,
	output logic signed [OUT_W-1:0] forward_z,
	output logic signed [OUT_W-1:0] right_x,
	output logic signed [OUT_W-1:0] right_y,
	output logic signed [OUT_W-1:0] right_z,
	output logic signed [OUT_W-1:0] up_x,
	output logic signed [OUT_W-1:0] up_y,
	output logic signed [OUT_W-1:0] up_z
);

	localparam int LAT = CORDIC_STEPS + 2 + 5;

	logic           adv;
	logic [LAT-1:0] vld_q;
	trig_t          trig_p, trig_y, trig_r;

	// Advance unless a finished result is held
	assign adv      = ~(vld_q[LAT-1] & out_stall);
	assign in_stall = ~adv;

	// Track which stages carry a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[LAT-1];

	eatbv_trig_chain u_trig_p (
		.clk  (clk),
		.en   (adv),
		.angle(pitch),
		.trig (trig_p)
	);

	eatbv_trig_chain u_trig_y (
		.clk  (clk),
		.en   (adv),
		.angle(yaw),
		.trig (trig_y)
	);

	eatbv_trig_chain u_trig_r (
		.clk  (clk),
		.en   (adv),
		.angle(roll),
		.trig (trig_r)
	);

	eatbv_basis u_basis (
		.clk      (clk),
		.en       (adv),
		.p        (trig_p),
		.y        (trig_y),
		.r        (trig_r),
		.forward_x(forward_x),
		.forward_y(forward_y),
		.forward_z(forward_z),
		.right_x  (right_x),
		.right_y  (right_y),
		.right_z  (right_z),
		.up_x     (up_x),
		.up_y     (up_y),
		.up_z     (up_z)
	);

endmodule

// ===== rtl/core/eatbv_cordic_cell.sv =====
`timescale 1ns / 1ps

module eatbv_cordic_cell import eatbv_pkg::*; #(
	parameter int unsigned STEP = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q
);

	cordic_t st_s1;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;

	assign xs = d.x >>> STEP;
	assign ys = d.y >>> STEP;

	// Rotate one step towards zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			st_s1.neg_cos <= d.neg_cos;
			if (!d.z[Z_W-1]) begin
				st_s1.x <= d.x - ys;
				st_s1.y <= d.y + xs;
				st_s1.z <= d.z - ATAN_DEG16[STEP];
			end else begin
				st_s1.x <= d.x + ys;
				st_s1.y <= d.y - xs;
				st_s1.z <= d.z + ATAN_DEG16[STEP];
			end
		end
	end

	assign q = st_s1;

endmodule

// ===== rtl/core/eatbv_trig_chain.sv =====
`timescale 1ns / 1ps

module eatbv_trig_chain import eatbv_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [ANGLE_W-1:0] angle,
	output trig_t                     trig
);

	cordic_t prep_s1;
	cordic_t link [CORDIC_STEPS+1];
	trig_t   trig_s2;

	logic signed [16:0] a_in;
	logic signed [16:0] a_wrap;
	logic signed [16:0] a_fold;
	logic               neg;

	// Wrap once by 360 degrees, then fold into the right half-plane
	always_comb begin
		a_in = 17'(angle);
		if (a_in > 17'sd23040) begin
			a_wrap = a_in - 17'sd46080;
		end else if (a_in < -17'sd23040) begin
			a_wrap = a_in + 17'sd46080;
		end else begin
			a_wrap = a_in;
		end
		neg = 1'b0;
		if (a_wrap > 17'sd11520) begin
			a_fold = 17'sd23040 - a_wrap;
			neg    = 1'b1;
		end else if (a_wrap < -17'sd11520) begin
			a_fold = -17'sd23040 - a_wrap;
			neg    = 1'b1;
		end else begin
			a_fold = a_wrap;
		end
	end

	// Load the first cell's operands
	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1.x       <= CORDIC_GAIN;
			prep_s1.y       <= '0;
			prep_s1.z       <= Z_W'(a_fold) <<< 9;
			prep_s1.neg_cos <= neg;
		end
	end

	assign link[0] = prep_s1;

	// Row of rotation cells
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		eatbv_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk(clk),
			.en (en),
			.d  (link[i]),
			.q  (link[i+1])
		);
	end

	logic signed [XY_W-1:0]   sn_r;
	logic signed [XY_W-1:0]   cs_r;
	logic signed [TRIG_W-1:0] cs_n;

	// Round to scale 2^20 and restore the cosine sign
	always_comb begin
		sn_r = link[CORDIC_STEPS].y + XY_W'(128);
		cs_r = link[CORDIC_STEPS].x + XY_W'(128);
		cs_n = cs_r[TRIG_W+7:8];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s2.sn <= sn_r[TRIG_W+7:8];
			trig_s2.cs <= link[CORDIC_STEPS].neg_cos ? -cs_n : cs_n;
		end
	end

	assign trig = trig_s2;

endmodule

// ===== rtl/core/eatbv_basis.sv =====
`timescale 1ns / 1ps

module eatbv_basis import eatbv_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  trig_t                   p,
	input  trig_t                   y,
	input  trig_t                   r,
	output logic signed [OUT_W-1:0] forward_x,
	output logic signed [OUT_W-1:0] forward_y,
	output logic signed [OUT_W-1:0] forward_z,
	output logic signed [OUT_W-1:0] right_x,
	output logic signed [OUT_W-1:0] right_y,
	output logic signed [OUT_W-1:0] right_z,
	output logic signed [OUT_W-1:0] up_x,
	output logic signed [OUT_W-1:0] up_y,
	output logic signed [OUT_W-1:0] up_z
);

	localparam int P2_W  = 2 * TRIG_W;
	localparam int SPLIT = TRIG_W;
	localparam int PP_W  = 2 * TRIG_W + 1;
	localparam int TMP_W = 66;
	localparam int RND_W = 19;
	localparam int LIFT  = 20;

	localparam logic signed [TMP_W-1:0] ONE   = 1;
	localparam logic signed [RND_W-1:0] Q_POS = 16384;
	localparam logic signed [RND_W-1:0] Q_NEG = -16384;

	function automatic logic signed [RND_W-1:0] rnd(
		input logic signed [TMP_W-1:0] v,
		input int unsigned             s
	);
		logic signed [TMP_W-1:0] t;
		t = v + (ONE <<< (s - 1));
		t = t >>> s;
		return t[RND_W-1:0];
	endfunction

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [RND_W-1:0] v);
		logic signed [RND_W-1:0] t;
		if (v > Q_POS) begin
			t = Q_POS;
		end else if (v < Q_NEG) begin
			t = Q_NEG;
		end else begin
			t = v;
		end
		return t[OUT_W-1:0];
	endfunction

	// Stage 1: two-factor products
	logic signed [P2_W-1:0]   spcy_s1, spsy_s1, cpcy_s1, cpsy_s1, srcp_s1, crcp_s1;
	logic signed [P2_W-1:0]   crsy_s1, crcy_s1, srsy_s1, srcy_s1;
	logic signed [TRIG_W-1:0] sp_s1, sr_s1, cr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			spcy_s1 <= p.sn * y.cs;
			spsy_s1 <= p.sn * y.sn;
			cpcy_s1 <= p.cs * y.cs;
			cpsy_s1 <= p.cs * y.sn;
			srcp_s1 <= r.sn * p.cs;
			crcp_s1 <= r.cs * p.cs;
			crsy_s1 <= r.cs * y.sn;
			crcy_s1 <= r.cs * y.cs;
			srsy_s1 <= r.sn * y.sn;
			srcy_s1 <= r.sn * y.cs;
			sp_s1   <= p.sn;
			sr_s1   <= r.sn;
			cr_s1   <= r.cs;
		end
	end

	// Stage 2: partial products of the three-factor terms
	logic signed [SPLIT:0]        spcy_lo, spsy_lo;
	logic signed [P2_W-SPLIT-1:0] spcy_hi, spsy_hi;

	always_comb begin
		spcy_lo = {1'b0, spcy_s1[SPLIT-1:0]};
		spsy_lo = {1'b0, spsy_s1[SPLIT-1:0]};
		spcy_hi = spcy_s1[P2_W-1:SPLIT];
		spsy_hi = spsy_s1[P2_W-1:SPLIT];
	end

	logic signed [PP_W-1:0]   srpc_lo_s2, srpc_hi_s2, crpc_lo_s2, crpc_hi_s2;
	logic signed [PP_W-1:0]   srps_lo_s2, srps_hi_s2, crps_lo_s2, crps_hi_s2;
	logic signed [P2_W-1:0]   cpcy_s2, cpsy_s2, srcp_s2, crcp_s2;
	logic signed [P2_W-1:0]   crsy_s2, crcy_s2, srsy_s2, srcy_s2;
	logic signed [TRIG_W-1:0] sp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			srpc_lo_s2 <= sr_s1 * spcy_lo;
			srpc_hi_s2 <= sr_s1 * spcy_hi;
			crpc_lo_s2 <= cr_s1 * spcy_lo;
			crpc_hi_s2 <= cr_s1 * spcy_hi;
			srps_lo_s2 <= sr_s1 * spsy_lo;
			srps_hi_s2 <= sr_s1 * spsy_hi;
			crps_lo_s2 <= cr_s1 * spsy_lo;
			crps_hi_s2 <= cr_s1 * spsy_hi;
			cpcy_s2    <= cpcy_s1;
			cpsy_s2    <= cpsy_s1;
			srcp_s2    <= srcp_s1;
			crcp_s2    <= crcp_s1;
			crsy_s2    <= crsy_s1;
			crcy_s2    <= crcy_s1;
			srsy_s2    <= srsy_s1;
			srcy_s2    <= srcy_s1;
			sp_s2      <= sp_s1;
		end
	end

	// Stage 3: join partial products into exact three-factor terms
	logic signed [TMP_W-1:0]  srpc_s3, crpc_s3, srps_s3, crps_s3;
	logic signed [P2_W-1:0]   cpcy_s3, cpsy_s3, srcp_s3, crcp_s3;
	logic signed [P2_W-1:0]   crsy_s3, crcy_s3, srsy_s3, srcy_s3;
	logic signed [TRIG_W-1:0] sp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			srpc_s3 <= (TMP_W'(srpc_hi_s2) <<< SPLIT) + TMP_W'(srpc_lo_s2);
			crpc_s3 <= (TMP_W'(crpc_hi_s2) <<< SPLIT) + TMP_W'(crpc_lo_s2);
			srps_s3 <= (TMP_W'(srps_hi_s2) <<< SPLIT) + TMP_W'(srps_lo_s2);
			crps_s3 <= (TMP_W'(crps_hi_s2) <<< SPLIT) + TMP_W'(crps_lo_s2);
			cpcy_s3 <= cpcy_s2;
			cpsy_s3 <= cpsy_s2;
			srcp_s3 <= srcp_s2;
			crcp_s3 <= crcp_s2;
			crsy_s3 <= crsy_s2;
			crcy_s3 <= crcy_s2;
			srsy_s3 <= srsy_s2;
			srcy_s3 <= srcy_s2;
			sp_s3   <= sp_s2;
		end
	end

	// Stage 4: sum and round half up to Q1.14
	logic signed [RND_W-1:0] fx_s4, fy_s4, fz_s4, rx_s4, ry_s4, rz_s4, ux_s4, uy_s4, uz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s4 <= rnd(TMP_W'(cpcy_s3), 26);
			fy_s4 <= rnd(TMP_W'(cpsy_s3), 26);
			fz_s4 <= rnd(-TMP_W'(sp_s3), 6);
			rx_s4 <= rnd(-srpc_s3 + (TMP_W'(crsy_s3) <<< LIFT), 46);
			ry_s4 <= rnd(-srps_s3 - (TMP_W'(crcy_s3) <<< LIFT), 46);
			rz_s4 <= rnd(-TMP_W'(srcp_s3), 26);
			ux_s4 <= rnd(crpc_s3 + (TMP_W'(srsy_s3) <<< LIFT), 46);
			uy_s4 <= rnd(crps_s3 - (TMP_W'(srcy_s3) <<< LIFT), 46);
			uz_s4 <= rnd(TMP_W'(crcp_s3), 26);
		end
	end

	// Stage 5: saturate into the output register
	logic signed [OUT_W-1:0] fx_s5, fy_s5, fz_s5, rx_s5, ry_s5, rz_s5, ux_s5, uy_s5, uz_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s5 <= sat(fx_s4);
			fy_s5 <= sat(fy_s4);
			fz_s5 <= sat(fz_s4);
			rx_s5 <= sat(rx_s4);
			ry_s5 <= sat(ry_s4);
			rz_s5 <= sat(rz_s4);
			ux_s5 <= sat(ux_s4);
			uy_s5 <= sat(uy_s4);
			uz_s5 <= sat(uz_s4);
		end
	end

	assign forward_x = fx_s5;
	assign forward_y = fy_s5;
	assign forward_z = fz_s5;
	assign right_x   = rx_s5;
	assign right_y   = ry_s5;
	assign right_z   = rz_s5;
	assign up_x      = ux_s5;
	assign up_y      = uy_s5;
	assign up_z      = uz_s5;

endmodule
